### src/q16_16_fixed_point_alu_defines.svh
// Assertion macros shared by the fixed-point unit.
`ifndef Q16_16_FIXED_POINT_ALU_DEFINES_SVH
`define Q16_16_FIXED_POINT_ALU_DEFINES_SVH
`ifndef SYNTH
`define FX_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define FX_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define FX_ASSERT(lbl, clk, rstn, prop)
`define FX_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point unit package
// Operation codes, pipeline sideband type and default constants.
// ----------------------------------------------------------------------------
package fxalu_pkg;
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_IDIV  = 4'd4,
    CMD_MOD   = 4'd5,
    CMD_FLOOR = 4'd6,
    CMD_CEIL  = 4'd7,
    CMD_ROUND = 4'd8,
    CMD_FRAC  = 4'd9,
    CMD_ABS   = 4'd10,
    CMD_NEG   = 4'd11,
    CMD_SIGN  = 4'd12
  } cmd_e;

  typedef struct packed {
    logic              vld;
    logic [3:0]        cmd;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              neg;
  } side_t;
endpackage

### src/q16_16_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Q16.16 fixed-point arithmetic unit
// The latency is set by the chain of one divider cell per quotient bit plus
// the input, fixup, multiply and output stages. One beat is accepted every
// cycle and busy stays low.
// Reset clears the pipeline valid bits and sets infinity to 0x7FFFFFFF.
// ----------------------------------------------------------------------------
`include "q16_16_fixed_point_alu_defines.svh"
module q16_16_fixed_point_alu #(
  parameter int unsigned FRACTION_BITS = fxalu_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  cmd_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        result_valid_o,
  output logic signed [31:0] result_value_o,
  output logic        divided_by_zero_o
);
  import fxalu_pkg::*;

  localparam int unsigned NB = 32 + FRACTION_BITS;
  localparam logic [31:0] ONE = 32'd1 << FRACTION_BITS;
  localparam logic [31:0] HALF = ONE >> 1;
  localparam logic [31:0] FRAC_MASK = ONE - 32'd1;

  logic [30:0] inf_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {1'b0, inf_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q <= 31'h7FFFFFFF;
    end else if (cfg_wr) begin
      inf_q <= pwdata[30:0];
    end
  end

  side_t         sd   [0:NB];
  logic [31:0]   rem  [0:NB];
  logic [NB-1:0] dq   [0:NB];
  logic [31:0]   dv   [0:NB];

  logic [31:0] amag, bmag;
  logic        vld0_q;
  side_t       s0_q;
  logic [NB-1:0] dq0_q;
  logic [31:0] d0_q;

  always_comb begin
    amag = operand_a_i[31] ? 32'd0 - operand_a_i : operand_a_i;
    bmag = operand_b_i[31] ? 32'd0 - operand_b_i : operand_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q.vld <= 1'b1;
    s0_q.cmd <= cmd_i;
    s0_q.a   <= operand_a_i;
    s0_q.b   <= operand_b_i;
    s0_q.neg <= operand_a_i[31] ^ operand_b_i[31];
    dq0_q    <= {amag, {FRACTION_BITS{1'b0}}};
    d0_q     <= bmag;
  end

  always_comb begin
    sd[0]     = s0_q;
    sd[0].vld = vld0_q;
  end
  assign rem[0] = 32'd0;
  assign dq[0]  = dq0_q;
  assign dv[0]  = d0_q;

  for (genvar k = 0; k < NB; k++) begin : g_cell
    fxalu_div_cell #(.NB(NB)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .side_i (sd[k]),
      .rem_i  (rem[k]),
      .dq_i   (dq[k]),
      .d_i    (dv[k]),
      .side_o (sd[k+1]),
      .rem_o  (rem[k+1]),
      .dq_o   (dq[k+1]),
      .d_o    (dv[k+1])
    );
  end

  // Quotient sign fixup and zero-divisor handling.
  side_t       se, e_q, m_q;
  logic        e_vld_q, m_vld_q;
  logic [31:0] qmag, div_d, div_e_q, div_m_q;
  logic        dz_d, dz_e_q, dz_m_q, divop;

  assign se   = sd[NB];
  assign qmag = dq[NB][31:0];

  always_comb begin
    divop = (se.cmd == CMD_DIV) || (se.cmd == CMD_IDIV) || (se.cmd == CMD_MOD);
    dz_d  = divop && (se.b == 32'd0);
    if (se.b == 32'd0) begin
      div_d = se.a[31] ? 32'd0 - {1'b0, inf_q} : {1'b0, inf_q};
    end else begin
      div_d = se.neg ? 32'd0 - qmag : qmag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      e_vld_q <= se.vld;
      m_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= se;
    div_e_q <= div_d;
    dz_e_q  <= dz_d;
  end

  logic [31:0]        ma;
  logic signed [63:0] prod_d, prod_q;

  always_comb begin
    ma     = (e_q.cmd == CMD_MUL) ? e_q.a : (div_e_q & ~FRAC_MASK);
    prod_d = $signed(ma) * $signed(e_q.b);
  end

  always_ff @(posedge clk_i) begin
    m_q     <= e_q;
    div_m_q <= div_e_q;
    dz_m_q  <= dz_e_q;
    prod_q  <= prod_d;
  end

  logic [31:0] mulr, res_d, fl;
  logic        out_vld_q, out_dz_q;
  logic [31:0] out_val_q;
  logic [3:0]  out_cmd_q;

  always_comb begin
    mulr = prod_q[FRACTION_BITS +: 32];
    fl   = m_q.a & ~FRAC_MASK;
    unique case (m_q.cmd)
      CMD_ADD:   res_d = m_q.a + m_q.b;
      CMD_SUB:   res_d = m_q.a - m_q.b;
      CMD_MUL:   res_d = mulr;
      CMD_DIV:   res_d = div_m_q;
      CMD_IDIV:  res_d = div_m_q & ~FRAC_MASK;
      CMD_MOD:   res_d = dz_m_q ? m_q.a : m_q.a - mulr;
      CMD_FLOOR: res_d = fl;
      CMD_CEIL:  res_d = ((m_q.a & FRAC_MASK) != 32'd0) ? fl + ONE : fl;
      CMD_ROUND: res_d = (m_q.a + HALF) & ~FRAC_MASK;
      CMD_FRAC:  res_d = m_q.a & FRAC_MASK;
      CMD_ABS:   res_d = m_q.a[31] ? 32'd0 - m_q.a : m_q.a;
      CMD_NEG:   res_d = 32'd0 - m_q.a;
      CMD_SIGN:  res_d = m_q.a[31] ? 32'd0 - ONE : ONE;
      default:   res_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= res_d;
    out_dz_q  <= dz_m_q;
    out_cmd_q <= m_q.cmd;
  end

  assign result_valid_o    = out_vld_q;
  assign result_value_o    = out_val_q;
  assign divided_by_zero_o = out_dz_q;

  `FX_ASSERT_IMPL(a_dz_divop, clk_i, rst_ni, result_valid_o && divided_by_zero_o, (out_cmd_q == CMD_DIV) || (out_cmd_q == CMD_IDIV) || (out_cmd_q == CMD_MOD))
  `FX_ASSERT_IMPL(a_sign_val, clk_i, rst_ni, result_valid_o && (out_cmd_q == CMD_SIGN), (result_value_o == ONE) || (result_value_o == 32'd0 - ONE))
  `FX_ASSERT_IMPL(a_frac_val, clk_i, rst_ni, result_valid_o && (out_cmd_q == CMD_FRAC), (result_value_o & ~FRAC_MASK) == 32'd0)
endmodule

### src/fxalu_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: shifts in a dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit into the dividend word.
// ----------------------------------------------------------------------------
module fxalu_div_cell #(
  parameter int unsigned NB = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fxalu_pkg::side_t     side_i,
  input  logic [31:0]          rem_i,
  input  logic [NB-1:0]        dq_i,
  input  logic [31:0]          d_i,
  output fxalu_pkg::side_t     side_o,
  output logic [31:0]          rem_o,
  output logic [NB-1:0]        dq_o,
  output logic [31:0]          d_o
);
  import fxalu_pkg::*;

  logic [32:0]   t;
  logic          ge;
  logic [31:0]   rem_d, rem_q;
  logic [NB-1:0] dq_d, dq_q;
  logic [31:0]   d_q;
  side_t         side_q;
  logic          vld_q;
  logic [32:0]   diff;

  always_comb begin
    t     = {rem_i, dq_i[NB-1]};
    diff  = t - {1'b0, d_i};
    ge    = (t >= {1'b0, d_i});
    rem_d = ge ? diff[31:0] : t[31:0];
    dq_d  = {dq_i[NB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= side_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    d_q    <= d_i;
    side_q <= side_i;
  end

  always_comb begin
    side_o     = side_q;
    side_o.vld = vld_q;
  end
  assign rem_o = rem_q;
  assign dq_o  = dq_q;
  assign d_o   = d_q;
endmodule
